@@ hw/rtl/utf8v_pkg.sv @@
// Shared types and constants for the UTF-8 stream validator.
// Used by the front classifier, the item queue and the back checker.
`default_nettype none

package utf8v_pkg;

  // Width of the running byte position inside the stream.
  localparam int POSITION_BITS = 32;
  // Width of the reported error position.
  localparam int ERR_POS_BITS  = 32;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;

  // Broad kind of a byte when seen as a lead.
  typedef enum logic [1:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD,
    KIND_BAD
  } kind_t;

  // Constraint on the byte following a lead.
  typedef enum logic [2:0] {
    SB_NONE,
    SB_A0_BF,
    SB_80_9F,
    SB_90_BF,
    SB_80_8F
  } sbc_t;

  localparam int SBC_COUNT = 5;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic                 last;
    kind_t                kind;
    logic [1:0]           expect_cnt;
    sbc_t                 sbc;
    logic [SBC_COUNT-1:0] cont_ok;
  } item_t;

endpackage

`default_nettype wire

@@ hw/rtl/utf8v_front.sv @@
// Front part of the UTF-8 stream validator: classifies each incoming byte.
// Depends on utf8v_pkg; feeds utf8v_queue.
`default_nettype none

module utf8v_front
  import utf8v_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  output logic            push_valid,
  input  wire logic       push_ready,
  output item_t           push_item
);

  logic in_cont_range;

  assign in_cont_range = (in_data_byte[7:6] == 2'b10);
  assign in_ready      = push_ready;
  assign push_valid    = in_valid;

  always_comb begin
    push_item            = '0;
    push_item.last       = in_last;
    push_item.kind       = KIND_BAD;
    push_item.expect_cnt = 2'd0;
    push_item.sbc        = SB_NONE;

    if (in_data_byte <= 8'h7F) begin
      push_item.kind = KIND_ASCII;
    end else if (in_data_byte <= 8'hBF) begin
      push_item.kind = KIND_CONT;
    end else if (in_data_byte >= 8'hC2 && in_data_byte <= 8'hDF) begin
      push_item.kind       = KIND_LEAD;
      push_item.expect_cnt = 2'd1;
    end else if (in_data_byte >= 8'hE0 && in_data_byte <= 8'hEF) begin
      push_item.kind       = KIND_LEAD;
      push_item.expect_cnt = 2'd2;
      if (in_data_byte == 8'hE0) begin
        push_item.sbc = SB_A0_BF;
      end else if (in_data_byte == 8'hED) begin
        push_item.sbc = SB_80_9F;
      end
    end else if (in_data_byte >= 8'hF0 && in_data_byte <= 8'hF4) begin
      push_item.kind       = KIND_LEAD;
      push_item.expect_cnt = 2'd3;
      if (in_data_byte == 8'hF0) begin
        push_item.sbc = SB_90_BF;
      end else if (in_data_byte == 8'hF4) begin
        push_item.sbc = SB_80_8F;
      end
    end

    // Continuation checks against every possible pending constraint, so the
    // back part only has to select one.
    push_item.cont_ok[SB_NONE]  = in_cont_range;
    push_item.cont_ok[SB_A0_BF] = in_cont_range && (in_data_byte >= 8'hA0);
    push_item.cont_ok[SB_80_9F] = in_cont_range && (in_data_byte <= 8'h9F);
    push_item.cont_ok[SB_90_BF] = in_cont_range && (in_data_byte >= 8'h90);
    push_item.cont_ok[SB_80_8F] = in_cont_range && (in_data_byte <= 8'h8F);
  end

endmodule

`default_nettype wire

@@ hw/rtl/utf8v_queue.sv @@
// Short queue of classified items between the front and back parts.
// Depends on utf8v_pkg.
`default_nettype none

module utf8v_queue
  import utf8v_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_fire, pop_fire;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ hw/rtl/utf8v_back.sv @@
// Back part of the UTF-8 stream validator: sequence tracking and result register.
// Depends on utf8v_pkg; takes items from utf8v_queue.
`default_nettype none

module utf8v_back
  import utf8v_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    pop_valid,
  output logic                         pop_ready,
  input  wire item_t                   pop_item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_valid_res,
  output logic [ERR_POS_BITS-1:0]      out_error_position
);

  pos_t                    byte_count_r, byte_count_nxt;
  pos_t                    seq_start_r, seq_start_nxt;
  logic [1:0]              expect_r, expect_nxt;
  sbc_t                    sbc_r, sbc_nxt;
  logic                    err_r, err_nxt;
  pos_t                    err_pos_r, err_pos_nxt;
  logic                    out_valid_r;
  logic                    valid_res_r, valid_res_nxt;
  logic [ERR_POS_BITS-1:0] error_position_r, error_position_nxt;
  logic                    pop_fire;
  logic                    cont_ok;
  pos_t                    pos;

  // Only an item that ends the stream needs room in the result register.
  assign pop_ready = !pop_item.last || !out_valid_r || out_ready;
  assign pop_fire  = pop_valid && pop_ready;

  assign out_valid          = out_valid_r;
  assign out_valid_res      = valid_res_r;
  assign out_error_position = error_position_r;

  always_comb begin
    case (sbc_r)
      SB_A0_BF: cont_ok = pop_item.cont_ok[SB_A0_BF];
      SB_80_9F: cont_ok = pop_item.cont_ok[SB_80_9F];
      SB_90_BF: cont_ok = pop_item.cont_ok[SB_90_BF];
      SB_80_8F: cont_ok = pop_item.cont_ok[SB_80_8F];
      default:  cont_ok = pop_item.cont_ok[SB_NONE];
    endcase
  end

  always_comb begin
    byte_count_nxt     = byte_count_r;
    seq_start_nxt      = seq_start_r;
    expect_nxt         = expect_r;
    sbc_nxt            = sbc_r;
    err_nxt            = err_r;
    err_pos_nxt        = err_pos_r;
    valid_res_nxt      = valid_res_r;
    error_position_nxt = error_position_r;
    // The position saturates rather than wrapping on very long streams.
    pos = (byte_count_r == '1) ? byte_count_r : byte_count_r + pos_t'(1);

    if (pop_fire) begin
      byte_count_nxt = pos;
      if (!err_r) begin
        if (expect_r == 2'd0) begin
          seq_start_nxt = pos;
          sbc_nxt       = SB_NONE;
          case (pop_item.kind)
            KIND_ASCII: begin
              expect_nxt = 2'd0;
            end
            KIND_LEAD: begin
              expect_nxt = pop_item.expect_cnt;
              sbc_nxt    = pop_item.sbc;
            end
            default: begin
              err_nxt     = 1'b1;
              err_pos_nxt = pos;
              expect_nxt  = 2'd0;
            end
          endcase
        end else if (cont_ok) begin
          expect_nxt = expect_r - 2'd1;
          sbc_nxt    = SB_NONE;
        end else begin
          err_nxt     = 1'b1;
          err_pos_nxt = seq_start_r;
          expect_nxt  = 2'd0;
          sbc_nxt     = SB_NONE;
        end
      end

      if (pop_item.last) begin
        // A sequence still owing bytes at the end is truncated.
        if (!err_nxt && expect_nxt != 2'd0) begin
          err_nxt     = 1'b1;
          err_pos_nxt = seq_start_nxt;
        end
        valid_res_nxt      = !err_nxt;
        error_position_nxt = err_nxt ? ERR_POS_BITS'(err_pos_nxt) : '0;
        byte_count_nxt     = '0;
        seq_start_nxt      = '0;
        expect_nxt         = 2'd0;
        sbc_nxt            = SB_NONE;
        err_nxt            = 1'b0;
        err_pos_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      seq_start_r  <= '0;
      expect_r     <= 2'd0;
      sbc_r        <= SB_NONE;
      err_r        <= 1'b0;
      err_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      seq_start_r  <= seq_start_nxt;
      expect_r     <= expect_nxt;
      sbc_r        <= sbc_nxt;
      err_r        <= err_nxt;
      err_pos_r    <= err_pos_nxt;
      if (pop_fire && pop_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_res_r      <= valid_res_nxt;
    error_position_r <= error_position_nxt;
  end

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && pop_item.last) |=> (out_valid_r && expect_r == 2'd0 && !err_r
                                     && byte_count_r == '0))
    else $error("stream end did not give a result and clear the state");

  a_no_owe_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (expect_r == 2'd0 && sbc_r == SB_NONE))
    else $error("sequence still pending after an error");

  a_valid_has_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && valid_res_r) |-> (error_position_r == '0))
    else $error("valid stream reported with a position");

  a_constraint_needs_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (sbc_r != SB_NONE) |-> (expect_r >= 2'd2))
    else $error("second byte constraint without a pending sequence");

endmodule

`default_nettype wire

@@ hw/rtl/utf8_stream_validator.sv @@
// UTF-8 stream validator top level: front classifier, item queue, back checker.
// Result: the verdict is registered when the item marked last is taken from the queue.
// Throughput: one byte item per cycle, unless an item marked last waits on an untaken result.
// Stall: an item marked last waits in the queue while an earlier result is untaken.
// Reset: synchronous active-low rst_n empties the queue and clears all stream state.
`default_nettype none

module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_valid_res,
  output logic [ERR_POS_BITS-1:0]      out_error_position
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  utf8v_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  utf8v_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  utf8v_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_item           (pop_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_valid_res      (out_valid_res),
    .out_error_position (out_error_position)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the UTF-8 stream validator (utf8_stream_validator).
// It drives byte items and checks each stream verdict against a local predictor or the verdict typed in the plan.
// Depends on utf8v_pkg for the position widths and the second-byte rule codes.
`timescale 1ns / 100ps

module testbench;
  import utf8v_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 80;
  localparam int TAIL_CYCLES  = 8;
  localparam int STALL_LIMIT  = 1000;

  localparam logic LAST    = 1'b1;
  localparam logic MORE    = 1'b0;
  localparam logic TYPED   = 1'b1;
  localparam logic PREDICT = 1'b0;
  localparam logic GOOD    = 1'b1;
  localparam logic BAD     = 1'b0;

  typedef struct packed {
    logic                    ok;
    logic [ERR_POS_BITS-1:0] pos;
  } verdict_t;

  typedef struct packed {
    logic [7:0]              data;
    logic                    last;
    logic                    typed;
    logic                    ok;
    logic [ERR_POS_BITS-1:0] pos;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_data_byte = 8'h00;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_valid_res;
  logic [ERR_POS_BITS-1:0] out_error_position;

  // Local copy of the stream state.
  pos_t       stream_pos = '0;
  pos_t       lead_pos = '0;
  logic [1:0] owed = 2'd0;
  sbc_t       rule = SB_NONE;
  logic       seen_bad = 1'b0;
  pos_t       bad_pos = '0;

  verdict_t   verdict_q[$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;

  // Directed streams: extremes, each narrowed second-byte rule, and the error cases.
  plan_row_t byte_plan[26] = '{
    '{8'h00, LAST, TYPED,   GOOD, 32'd0},
    '{8'h7F, LAST, TYPED,   GOOD, 32'd0},
    '{8'h80, LAST, TYPED,   BAD,  32'd1},
    '{8'hFF, LAST, TYPED,   BAD,  32'd1},
    '{8'hC2, MORE, PREDICT, GOOD, 32'd0},
    '{8'hBF, LAST, PREDICT, GOOD, 32'd0},
    '{8'hC1, LAST, TYPED,   BAD,  32'd1},
    '{8'hE0, MORE, PREDICT, GOOD, 32'd0},
    '{8'hA0, MORE, PREDICT, GOOD, 32'd0},
    '{8'h80, LAST, PREDICT, GOOD, 32'd0},
    '{8'hE0, MORE, PREDICT, GOOD, 32'd0},
    '{8'h9F, LAST, TYPED,   BAD,  32'd1},
    '{8'hED, MORE, PREDICT, GOOD, 32'd0},
    '{8'hA0, LAST, TYPED,   BAD,  32'd1},
    '{8'hF4, MORE, PREDICT, GOOD, 32'd0},
    '{8'h8F, MORE, PREDICT, GOOD, 32'd0},
    '{8'hBF, MORE, PREDICT, GOOD, 32'd0},
    '{8'hBF, LAST, PREDICT, GOOD, 32'd0},
    '{8'hF0, MORE, PREDICT, GOOD, 32'd0},
    '{8'h8F, LAST, TYPED,   BAD,  32'd1},
    '{8'hF5, LAST, TYPED,   BAD,  32'd1},
    '{8'h41, MORE, PREDICT, GOOD, 32'd0},
    '{8'hE1, MORE, PREDICT, GOOD, 32'd0},
    '{8'h80, LAST, TYPED,   BAD,  32'd2},
    '{8'hC2, MORE, PREDICT, GOOD, 32'd0},
    '{8'h41, LAST, TYPED,   BAD,  32'd1}
  };

  utf8_stream_validator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_valid_res      (out_valid_res),
    .out_error_position (out_error_position)
  );

  always #5 clk = ~clk;

  function automatic logic cont_fits(input logic [7:0] b, input sbc_t r);
    if (b < 8'h80 || b > 8'hBF) return 1'b0;
    case (r)
      SB_A0_BF: return b >= 8'hA0;
      SB_80_9F: return b <= 8'h9F;
      SB_90_BF: return b >= 8'h90;
      SB_80_8F: return b <= 8'h8F;
      default:  return 1'b1;
    endcase
  endfunction

  task automatic mark_bad(input pos_t p);
    seen_bad = 1'b1;
    bad_pos  = p;
    owed     = 2'd0;
    rule     = SB_NONE;
  endtask

  // Advances the stream state by one byte; gives a verdict when the byte ends the stream.
  task automatic judge_byte(input logic [7:0] b, input logic l, output bit has,
                            output verdict_t v);
    has = 1'b0;
    v   = '0;
    if (stream_pos != '1) stream_pos = stream_pos + 1'b1;
    if (!seen_bad) begin
      if (owed == 2'd0) begin
        lead_pos = stream_pos;
        rule     = SB_NONE;
        if (b <= 8'h7F) begin
          owed = 2'd0;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          owed = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          owed = 2'd2;
          if (b == 8'hE0) rule = SB_A0_BF;
          else if (b == 8'hED) rule = SB_80_9F;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          owed = 2'd3;
          if (b == 8'hF0) rule = SB_90_BF;
          else if (b == 8'hF4) rule = SB_80_8F;
        end else begin
          mark_bad(stream_pos);
        end
      end else if (cont_fits(b, rule)) begin
        owed = owed - 2'd1;
        rule = SB_NONE;
      end else begin
        // The offending byte is not looked at again as a lead.
        mark_bad(lead_pos);
      end
    end
    if (l) begin
      if (!seen_bad && owed != 2'd0) mark_bad(lead_pos);
      has   = 1'b1;
      v.ok  = !seen_bad;
      v.pos = seen_bad ? ERR_POS_BITS'(bad_pos) : '0;
      stream_pos = '0;
      lead_pos   = '0;
      owed       = 2'd0;
      rule       = SB_NONE;
      seen_bad   = 1'b0;
      bad_pos    = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input logic t_ok, input logic [ERR_POS_BITS-1:0] t_pos);
    bit       has;
    verdict_t v;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    judge_byte(b, l, has, v);
    if (has) begin
      if (typed) begin
        v.ok  = t_ok;
        v.pos = t_pos;
      end
      verdict_q.push_back(v);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off requested by the sender.
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result valid_res=%0b error_position=%0d",
                 $time, out_valid_res, out_error_position);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_valid_res !== want.ok || out_error_position !== want.pos) begin
          $display("%0t: mismatch: expected valid_res=%0b error_position=%0d, got %0b %0d",
                   $time, want.ok, want.pos, out_valid_res, out_error_position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [7:0] stream[$];
    logic [7:0] v;
    int         sent;
    int         streams;
    int         kind;
    int         choice;
    int         lead;
    int         lo;
    int         hi;
    bit         drained;
    sent    = 0;
    streams = 0;
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (byte_plan[i])
      send_byte(byte_plan[i].data, byte_plan[i].last, byte_plan[i].typed,
                byte_plan[i].ok, byte_plan[i].pos);

    while (sent < RANDOM_ITEMS) begin
      stream.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          choice = $urandom_range(0, 3);
          case (choice)
            0: stream.push_back(8'($urandom_range(0, 127)));
            1: begin
              stream.push_back(8'($urandom_range(8'hC2, 8'hDF)));
              stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: begin
              // The narrowed leads come up more often than their share.
              if (choice == 2)
                lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'hE0 : 8'hED)
                                                   : $urandom_range(8'hE0, 8'hEF);
              else
                lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'hF0 : 8'hF4)
                                                   : $urandom_range(8'hF0, 8'hF4);
              lo = 8'h80;
              hi = 8'hBF;
              case (lead)
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
              endcase
              v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) ? lo : hi)
                                              : 8'($urandom_range(lo, hi));
              stream.push_back(8'(lead));
              stream.push_back(v);
              repeat ((lead >= 8'hF0) ? 2 : 1)
                stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
          endcase
        end
        if (kind < 40) begin
          case ($urandom_range(0, 2))
            0: stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
            1: if (stream.size() > 1) void'(stream.pop_back());
            default: stream.insert($urandom_range(0, stream.size()),
                                   8'($urandom_range(8'h80, 8'hBF)));
          endcase
        end
      end

      if (streams == 4) hold_req = 1'b1;
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        // Let the block empty out completely before carrying on.
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      quiet = (sent >= RANDOM_ITEMS * 5 / 6);

      foreach (stream[j])
        send_byte(stream[j], (j == stream.size() - 1), PREDICT, GOOD, '0);
      sent += stream.size();
      streams++;
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
